/* hdl/chm_pkg.sv */
// chm_pkg: constants, codes and types for the chained hash multimap.
// No dependencies; imported by chained_hash_multimap, chm_checker and chained_hash_multimap_tb.
package chm_pkg;

    localparam int BUCKET_BITS = 7;
    localparam int NODES       = 64;
    localparam int NBUCKETS    = 1 << BUCKET_BITS;
    localparam int PTR_W       = 7;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 64;
    localparam int CNT_W       = 7;
    localparam logic [63:0] FIB_MULT = 64'd11400714819323198485;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_ERASE = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_MATCH = 2'd1,
        ST_NONE  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_HEAD,
        S_DISPATCH,
        S_FREEPOP,
        S_WALK_RD,
        S_WALK_CHK,
        S_OUT
    } state_t;

endpackage

/* hdl/chained_hash_multimap.sv */
// chained_hash_multimap: hash multimap with separate chaining over a fixed node store.
// Depends on chm_pkg. Single module with node memories and a sequencer.
//
//  channel | dir | handshake        | contents
//  s_      | in  | tvalid/tready    | tdata = command[1:0], key[33:2], value[97:34]
//  m_      | out | tvalid/tready    | tdata = status, found_value, removed_count,
//          |     |                  |         entries_held; tlast = last
//
// The 64x64 hash product is built from three 32x32 partial products (high by high
// drops out mod 2^64) on one multiplier in S_MUL0, S_MUL1 and S_MUL2; a put that
// pops the free list also passes S_FREEPOP, and each chain node walked passes
// S_WALK_RD, which registers the node memory read, and then S_WALK_CHK.
// Reset clears bucket heads through valid bits; node memories are not cleared.
// Input is ready only between items. A stalled result holds in the output register
// and holds the walk; the final result of one item may still wait there while the
// next item is accepted. A get keeps each match back one step so the final match
// can carry tlast.
module chained_hash_multimap (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], key[33:2], value[97:34], zero fill to 104
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], found_value[65:2], removed_count[72:66], entries_held[79:73]
    output logic [79:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    import chm_pkg::*;

    // node memories
    logic [KEY_W-1:0] node_keys  [NODES];
    logic [VAL_W-1:0] node_values[NODES];
    logic [PTR_W-1:0] node_links [NODES];
    logic [PTR_W-1:0] bucket_heads[NBUCKETS];
    logic [NBUCKETS-1:0] head_valid_reg;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [63:0] prod_reg;
    logic [63:0] mul_out;
    logic [31:0] mul_a, mul_b;
    logic [BUCKET_BITS-1:0] bkt_reg;
    logic [PTR_W-1:0] head_reg, cur_reg, prev_reg, nxt_reg, node_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic [VAL_W-1:0] rd_val_reg;
    logic [PTR_W-1:0] rd_link_reg;
    logic [PTR_W-1:0] free_head_reg, unused_reg;
    logic [CNT_W-1:0] entries_reg, removed_reg, matches_reg;
    logic [VAL_W-1:0] hold_val_reg;
    logic [6:0] steps_reg;
    logic         out_valid_reg, out_last_reg;
    status_t      out_status_reg;
    logic [VAL_W-1:0] out_val_reg;
    logic [CNT_W-1:0] out_rem_reg;
    logic [63:0] key_sx;
    logic        out_free;

    assign key_sx = {{32{key_reg[31]}}, key_reg};
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {entries_reg, out_rem_reg, out_val_reg, out_status_reg};

    // shared 32x32 multiplier, three partial products (hi*hi drops out mod 2^64)
    always_comb begin
        unique case (state_reg)
            S_MUL1:  begin mul_a = key_sx[63:32]; mul_b = FIB_MULT[31:0];  end
            S_MUL2:  begin mul_a = key_sx[31:0];  mul_b = FIB_MULT[63:32]; end
            default: begin mul_a = key_sx[31:0];  mul_b = FIB_MULT[31:0];  end
        endcase
        mul_out = 64'(mul_a) * 64'(mul_b);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_axis_tvalid) state_next = S_MUL0;
            S_MUL0:     state_next = S_MUL1;
            S_MUL1:     state_next = S_MUL2;
            S_MUL2:     state_next = S_HEAD;
            S_HEAD:     state_next = S_DISPATCH;
            S_DISPATCH: begin
                unique case (cmd_reg)
                    CMD_PUT:   state_next = (free_head_reg != NIL) ? S_FREEPOP : S_OUT;
                    CMD_GET,
                    CMD_ERASE: state_next = (head_reg != NIL) ? S_WALK_RD : S_OUT;
                    default:   state_next = S_OUT;
                endcase
            end
            S_FREEPOP:  state_next = S_OUT;
            S_WALK_RD:  state_next = S_WALK_CHK;
            S_WALK_CHK: begin
                if (out_valid_reg && !m_axis_tready) state_next = S_WALK_CHK;
                else if (rd_link_reg == NIL || steps_reg == 7'(NODES - 1))
                    state_next = S_OUT;
                else state_next = S_WALK_RD;
            end
            S_OUT:      if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        // datapath and memories
        if (state_reg == S_IDLE && s_axis_tvalid) begin
            cmd_reg <= cmd_t'(s_axis_tdata[1:0]);
            key_reg <= s_axis_tdata[33:2];
            val_reg <= s_axis_tdata[97:34];
        end
        unique case (state_reg)
            S_MUL0: prod_reg <= mul_out;
            S_MUL1: prod_reg <= prod_reg + {mul_out[31:0], 32'd0};
            S_MUL2: prod_reg <= prod_reg + {mul_out[31:0], 32'd0};
            S_HEAD: begin
                bkt_reg  <= prod_reg[63 -: BUCKET_BITS];
                head_reg <= head_valid_reg[prod_reg[63 -: BUCKET_BITS]]
                          ? bucket_heads[prod_reg[63 -: BUCKET_BITS]] : NIL;
                cur_reg  <= NIL;
                prev_reg <= NIL;
                steps_reg <= '0;
                matches_reg <= '0;
                removed_reg <= '0;
            end
            S_DISPATCH: begin
                cur_reg  <= head_reg;
                nxt_reg  <= node_links[free_head_reg[5:0]];
                node_reg <= (free_head_reg != NIL) ? free_head_reg : unused_reg;
            end
            S_WALK_RD: begin
                rd_key_reg  <= node_keys[cur_reg[5:0]];
                rd_val_reg  <= node_values[cur_reg[5:0]];
                rd_link_reg <= node_links[cur_reg[5:0]];
            end
            S_WALK_CHK: if (!(out_valid_reg && !m_axis_tready)) begin
                if (cmd_reg == CMD_ERASE && rd_key_reg == key_reg) begin
                    if (prev_reg != NIL) node_links[prev_reg[5:0]] <= rd_link_reg;
                    else bucket_heads[bkt_reg] <= rd_link_reg;
                    node_links[cur_reg[5:0]] <= free_head_reg;
                end else if (cmd_reg == CMD_ERASE) begin
                    prev_reg <= cur_reg;
                end
                cur_reg   <= rd_link_reg;
                steps_reg <= steps_reg + 7'd1;
            end
            S_OUT: if (!out_valid_reg || m_axis_tready) begin
                if (cmd_reg == CMD_PUT && node_reg != NIL) begin
                    node_keys[node_reg[5:0]]   <= key_reg;
                    node_values[node_reg[5:0]] <= val_reg;
                    node_links[node_reg[5:0]]  <= head_reg;
                    bucket_heads[bkt_reg]      <= node_reg;
                end
            end
            default: ;
        endcase

        // control
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_valid_reg <= '0;
            free_head_reg  <= NIL;
            unused_reg     <= '0;
            entries_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_WALK_CHK && out_free && cmd_reg == CMD_ERASE
                    && rd_key_reg == key_reg && prev_reg == NIL)
                head_valid_reg[bkt_reg] <= 1'b1;
            else if (state_reg == S_OUT && out_free && cmd_reg == CMD_PUT
                    && node_reg != NIL)
                head_valid_reg[bkt_reg] <= 1'b1;

            // walk bookkeeping; a get match is held back one step
            if (state_reg == S_WALK_CHK && out_free && rd_key_reg == key_reg) begin
                if (cmd_reg == CMD_GET) begin
                    hold_val_reg <= rd_val_reg;
                    matches_reg  <= matches_reg + 7'd1;
                end else if (cmd_reg == CMD_ERASE) begin
                    free_head_reg <= cur_reg;
                    if (entries_reg != '0) entries_reg <= entries_reg - 7'd1;
                    removed_reg <= removed_reg + 7'd1;
                end
            end
            if (state_reg == S_FREEPOP) free_head_reg <= nxt_reg;
            if (state_reg == S_OUT && out_free && cmd_reg == CMD_PUT && node_reg != NIL) begin
                if (node_reg == unused_reg) unused_reg <= unused_reg + 7'd1;
                if (entries_reg < 7'(NODES)) entries_reg <= entries_reg + 7'd1;
            end

            // output register
            if (state_reg == S_WALK_CHK && out_free && cmd_reg == CMD_GET
                    && rd_key_reg == key_reg && matches_reg != '0) begin
                // a newer match arrived, so the held one is not the last
                out_valid_reg  <= 1'b1;
                out_status_reg <= ST_MATCH;
                out_val_reg    <= hold_val_reg;
                out_rem_reg    <= '0;
                out_last_reg   <= 1'b0;
            end else if (state_reg == S_OUT && out_free) begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= 1'b1;
                unique case (cmd_reg)
                    CMD_PUT: begin
                        out_status_reg <= (node_reg == NIL) ? ST_FULL : ST_DONE;
                        out_val_reg    <= '0;
                        out_rem_reg    <= '0;
                    end
                    CMD_GET: begin
                        out_status_reg <= (matches_reg != '0) ? ST_MATCH : ST_NONE;
                        out_val_reg    <= (matches_reg != '0) ? hold_val_reg : '0;
                        out_rem_reg    <= '0;
                    end
                    CMD_ERASE: begin
                        out_status_reg <= ST_DONE;
                        out_val_reg    <= '0;
                        out_rem_reg    <= removed_reg;
                    end
                    default: begin
                        out_status_reg <= ST_DONE;
                        out_val_reg    <= '0;
                        out_rem_reg    <= '0;
                    end
                endcase
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* sim/chm_checker.sv */
// chm_checker: watches both streams of chained_hash_multimap, predicts results, compares.
// Depends on chm_pkg; instantiated by chained_hash_multimap_tb beside the block.
module chm_checker
    import chm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [79:0]  m_axis_tdata,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending,
    output int           results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t          status;
        logic [VAL_W-1:0] found_value;
        logic             last;
        logic [CNT_W-1:0] removed;
        logic [CNT_W-1:0] held;
    } result_t;

    logic [PTR_W-1:0] heads [NBUCKETS];
    logic [KEY_W-1:0] keys  [NODES];
    logic [VAL_W-1:0] vals  [NODES];
    logic [PTR_W-1:0] links [NODES];
    logic [PTR_W-1:0] free_head, fresh_next;
    logic [CNT_W-1:0] held_cnt;
    result_t          awaited [$];

    function automatic logic [BUCKET_BITS-1:0] bucket_index(logic [KEY_W-1:0] key);
        logic [63:0] prod;
        prod = {{32{key[31]}}, key} * FIB_MULT;
        return prod[63 -: BUCKET_BITS];
    endfunction

    function automatic result_t mk(status_t st, logic [VAL_W-1:0] v, logic l,
                                   logic [CNT_W-1:0] rm);
        result_t r;
        r.status = st; r.found_value = v; r.last = l; r.removed = rm; r.held = held_cnt;
        return r;
    endfunction

    task automatic predict_item(logic [103:0] d);
        cmd_t             op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [BUCKET_BITS-1:0] b;
        int               hits;
        logic [PTR_W-1:0] n, cur, prev, nxt;
        op = cmd_t'(d[1:0]); key = d[33:2]; value = d[97:34];
        b = bucket_index(key);
        case (op)
            CMD_PUT: begin
                if (free_head < NODES) begin
                    n = free_head; free_head = links[n[5:0]];
                end else if (fresh_next < NODES) begin
                    n = fresh_next; fresh_next++;
                end else begin
                    awaited.push_back(mk(ST_FULL, '0, 1'b1, '0));
                    return;
                end
                keys[n[5:0]] = key; vals[n[5:0]] = value;
                links[n[5:0]] = heads[b]; heads[b] = n;
                if (held_cnt < NODES) held_cnt++;
                awaited.push_back(mk(ST_DONE, '0, 1'b1, '0));
            end
            CMD_GET: begin
                hits = 0; cur = heads[b];
                for (int s = 0; s < NODES && cur < NODES; s++) begin
                    if (keys[cur[5:0]] == key) begin
                        awaited.push_back(mk(ST_MATCH, vals[cur[5:0]], 1'b0, '0));
                        hits++;
                    end
                    cur = links[cur[5:0]];
                end
                if (hits == 0) awaited.push_back(mk(ST_NONE, '0, 1'b1, '0));
                else awaited[awaited.size()-1].last = 1'b1;
            end
            CMD_ERASE: begin
                hits = 0; prev = NIL; cur = heads[b];
                for (int s = 0; s < NODES && cur < NODES; s++) begin
                    nxt = links[cur[5:0]];
                    if (keys[cur[5:0]] != key) prev = cur;
                    else begin
                        if (prev < NODES) links[prev[5:0]] = nxt; else heads[b] = nxt;
                        links[cur[5:0]] = free_head; free_head = cur;
                        if (held_cnt > 0) held_cnt--;
                        hits++;
                    end
                    cur = nxt;
                end
                awaited.push_back(mk(ST_DONE, '0, 1'b1, CNT_W'(hits)));
            end
            default: awaited.push_back(mk(ST_DONE, '0, 1'b1, '0));
        endcase
    endtask

    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            heads      = '{default: NIL};
            free_head  = NIL;
            fresh_next = '0;
            held_cnt   = '0;
            awaited.delete();
            fail_count   <= 0;
            results_seen <= 0;
            pending      <= 0;
        end else begin
            // result side first: results of an item never appear in its accept cycle
            if (m_axis_tvalid && m_axis_tready) begin
                got = {status_t'(m_axis_tdata[1:0]), m_axis_tdata[65:2], m_axis_tlast,
                       m_axis_tdata[72:66], m_axis_tdata[79:73]};
                results_seen <= results_seen + 1;
                if (awaited.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("result mismatch: expected %p, got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tdata);
            pending <= awaited.size();
        end
    end
endmodule

/* sim/chained_hash_multimap_tb.sv */
// chained_hash_multimap_tb: drives directed and random put/get/erase traffic.
// Depends on chm_pkg, chained_hash_multimap and chm_checker (in sim/chm_checker.sv).
module chained_hash_multimap_tb;
    import chm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;
    logic         m_axis_tlast;
    int           fail_count, pending, results_seen;
    int           cycles = 0;
    bit           calm = 1'b0;      // no idling on either side in the last part
    bit           hold_sink = 1'b0; // long receiver hold-off for back-pressure
    int           items_sent = 0;

    // small key pool so gets and erases hit real chains
    logic [31:0]  key_pool [8] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                   32'h1, 32'h1234_5678, 32'hDEAD_BEEF, 32'h2};

    always #1 aclk = ~aclk;

    chained_hash_multimap uut (.*);

    chm_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_sink = 1'b0;
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // one transfer on the input stream; unless calm, valid may drop for a random gap first
    task automatic send_item(cmd_t op, logic [31:0] key, logic [63:0] value);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, value, key, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic logic [31:0] pick_key();
        return $urandom_range(0, 3) == 0 ? $urandom()
                                         : key_pool[3'($urandom_range(0, 7))];
    endfunction

    function automatic logic [63:0] rand_value();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        int r;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, misses, duplicates, no-op command
        send_item(CMD_GET,   32'h8000_0000, '0);               // miss on empty
        send_item(CMD_ERASE, 32'h7FFF_FFFF, '1);               // erase with no match
        send_item(CMD_NOP,   32'hFFFF_FFFF, '1);
        send_item(CMD_PUT,   32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_PUT,   32'h7FFF_FFFF, 64'h0);
        send_item(CMD_PUT,   32'h8000_0000, 64'hAAAA_5555_AAAA_5555);
        send_item(CMD_PUT,   32'h0,         64'h5555_AAAA_5555_AAAA);
        send_item(CMD_GET,   32'h8000_0000, '0);               // two hits, newest first
        send_item(CMD_GET,   32'hFFFF_FFFF, '0);
        send_item(CMD_ERASE, 32'h8000_0000, '0);
        send_item(CMD_GET,   32'h8000_0000, '0);
        // fill the store to overflow, reusing freed nodes, with back-pressure
        hold_sink = 1'b1;
        for (int i = 0; i < 66; i++) send_item(CMD_PUT, key_pool[3'(i % 8)], rand_value());
        send_item(CMD_GET,   32'h1, '0);                       // long chain of hits
        for (int i = 0; i < 8; i++) send_item(CMD_ERASE, key_pool[3'(i)], '0);
        send_item(CMD_PUT,   32'h2, 64'h1);

        // random: mostly puts and gets over the pool, some erases and noise
        for (int i = 0; i < 245; i++) begin
            if (i == 200) calm = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 45)      send_item(CMD_PUT, pick_key(), rand_value());
            else if (r < 75) send_item(CMD_GET, pick_key(), rand_value());
            else if (r < 95) send_item(CMD_ERASE, pick_key(), rand_value());
            else             send_item(CMD_NOP, $urandom(), rand_value());
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d commands (put/get/erase/nop, full store, reuse of freed nodes);",
                 items_sent);
        $display("checked %0d results under random stalls and a long receiver hold-off.",
                 results_seen);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
